FILE: hdl/thc_pkg.sv
// ============================================================================
// thc_pkg: shared types and constants for the tick housekeeping counters
// Command codes, register indexes, reset values and transaction payloads.
// ============================================================================
package thc_pkg;

    localparam int MAX_ROWS       = 4;
    localparam int ROWS_DEFAULT   = 4;
    localparam int CFG_DATA_W     = 15;

    localparam logic [14:0] REBOOT_LIMIT_RESET  = 15'd21600;
    localparam logic [5:0]  PERIOD_LENGTH_RESET = 6'd60;

    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_SET_COOLDOWN = 3'd1,
        CMD_SET_REFRESH  = 3'd2,
        CMD_SET_DELAY    = 3'd3,
        CMD_CLEAR_ALERT  = 3'd4,
        CMD_CLEAR_ARMED  = 3'd5,
        CMD_CLEAR_SUMS   = 3'd6
    } cmd_t;

    typedef enum logic {
        CFG_REBOOT_LIMIT  = 1'b0,
        CFG_PERIOD_LENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] write_value;
        logic               capture_on;
        logic               flush_pending;
        logic signed [15:0] row0_in;
        logic signed [15:0] row1_in;
        logic signed [15:0] row2_in;
        logic signed [15:0] row3_in;
    } thc_in_t;

    typedef struct packed {
        logic               reboot_request;
        logic               period_wrap;
        logic               alert_pending;
        logic               flush_request;
        logic signed [15:0] cooldown_count;
        logic signed [15:0] refresh_count;
        logic               deferred_armed;
        logic signed [15:0] row0_sum;
        logic signed [15:0] row1_sum;
        logic signed [15:0] row2_sum;
        logic signed [15:0] row3_sum;
        logic [3:0]         saturate_bits;
    } thc_out_t;

endpackage

FILE: hdl/thc_core.sv
// ============================================================================
// thc_core: counter state and single-pass update logic
// Holds all housekeeping state and computes the next state and the result
// for the transaction held in the input register.
// ============================================================================
module thc_core #(
    parameter int NUM_ROWS = thc_pkg::ROWS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  thc_pkg::thc_in_t item,
    input  logic [14:0]      reboot_limit,
    input  logic [5:0]       period_length,
    output thc_pkg::thc_out_t result
);

    logic [15:0] tick_reg, tick_next;
    logic [5:0]  period_reg, period_next;
    logic        alert_reg, alert_next;
    logic [15:0] cooldown_reg, cooldown_next;
    logic [15:0] refresh_reg, refresh_next;
    logic [15:0] delay_reg, delay_next;
    logic        armed_reg, armed_next;
    logic [NUM_ROWS-1:0][15:0] sum_reg, sum_next;
    logic [NUM_ROWS-1:0]       sat_reg, sat_next;

    logic [thc_pkg::MAX_ROWS-1:0][15:0] row_in;
    logic [NUM_ROWS-1:0][15:0]          row_add;
    logic [NUM_ROWS-1:0]                row_hit;
    logic [thc_pkg::MAX_ROWS-1:0][15:0] sum_out;
    logic [thc_pkg::MAX_ROWS-1:0]       sat_out;

    logic [15:0] tick_inc;
    logic [5:0]  period_inc;
    logic        delay_pos;
    logic        reboot, wrap, flush;

    assign row_in[0] = item.row0_in;
    assign row_in[1] = item.row1_in;
    assign row_in[2] = item.row2_in;
    assign row_in[3] = item.row3_in;

    assign tick_inc   = tick_reg + 16'd1;
    assign period_inc = period_reg + 6'd1;
    assign delay_pos  = !delay_reg[15] && (delay_reg != 16'd0);

    always_comb
    begin
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row_add[i] = sum_reg[i] + row_in[i];
            row_hit[i] = !row_add[i][15] && row_add[i][14];
        end
    end

    always_comb
    begin
        tick_next     = tick_reg;
        period_next   = period_reg;
        alert_next    = alert_reg;
        cooldown_next = cooldown_reg;
        refresh_next  = refresh_reg;
        delay_next    = delay_reg;
        armed_next    = armed_reg;
        sum_next      = sum_reg;
        sat_next      = sat_reg;
        reboot        = 1'b0;
        wrap          = 1'b0;
        flush         = 1'b0;
        case (item.command)
            thc_pkg::CMD_TICK:
            begin
                if (tick_inc == {1'b0, reboot_limit})
                begin
                    reboot        = 1'b1;
                    tick_next     = '0;
                    period_next   = '0;
                    alert_next    = 1'b0;
                    cooldown_next = '1;
                    refresh_next  = '1;
                    delay_next    = '0;
                    armed_next    = 1'b0;
                    sum_next      = '0;
                    sat_next      = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                    flush     = item.flush_pending;
                    if (period_inc == period_length)
                    begin
                        wrap        = 1'b1;
                        alert_next  = 1'b1;
                        period_next = '0;
                        if (!cooldown_reg[15])
                        begin
                            cooldown_next = cooldown_reg - 16'd1;
                        end
                        if (!refresh_reg[15])
                        begin
                            refresh_next = refresh_reg + 16'd1;
                        end
                        if (delay_pos)
                        begin
                            delay_next = delay_reg - 16'd1;
                            if (delay_reg == 16'd1)
                            begin
                                armed_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        period_next = period_inc;
                    end
                    if (item.capture_on)
                    begin
                        for (int i = 0; i < NUM_ROWS; i++)
                        begin
                            if (row_in[i] != 16'd0)
                            begin
                                if (row_hit[i])
                                begin
                                    sum_next[i] = '0;
                                    sat_next[i] = 1'b1;
                                end
                                else
                                begin
                                    sum_next[i] = row_add[i];
                                end
                            end
                        end
                    end
                end
            end
            thc_pkg::CMD_SET_COOLDOWN: cooldown_next = item.write_value;
            thc_pkg::CMD_SET_REFRESH:  refresh_next  = item.write_value;
            thc_pkg::CMD_SET_DELAY:    delay_next    = item.write_value;
            thc_pkg::CMD_CLEAR_ALERT:  alert_next    = 1'b0;
            thc_pkg::CMD_CLEAR_ARMED:  armed_next    = 1'b0;
            thc_pkg::CMD_CLEAR_SUMS:
            begin
                sum_next = '0;
                sat_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            period_reg   <= '0;
            alert_reg    <= 1'b0;
            cooldown_reg <= '1;
            refresh_reg  <= '1;
            delay_reg    <= '0;
            armed_reg    <= 1'b0;
            sum_reg      <= '0;
            sat_reg      <= '0;
        end
        else if (advance)
        begin
            tick_reg     <= tick_next;
            period_reg   <= period_next;
            alert_reg    <= alert_next;
            cooldown_reg <= cooldown_next;
            refresh_reg  <= refresh_next;
            delay_reg    <= delay_next;
            armed_reg    <= armed_next;
            sum_reg      <= sum_next;
            sat_reg      <= sat_next;
        end
    end

    always_comb
    begin
        sum_out = '0;
        sat_out = '0;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            sum_out[i] = sum_next[i];
            sat_out[i] = sat_next[i];
        end
    end

    always_comb
    begin
        result.reboot_request = reboot;
        result.period_wrap    = wrap;
        result.alert_pending  = alert_next;
        result.flush_request  = flush;
        result.cooldown_count = cooldown_next;
        result.refresh_count  = refresh_next;
        result.deferred_armed = armed_next;
        result.row0_sum       = sum_out[0];
        result.row1_sum       = sum_out[1];
        result.row2_sum       = sum_out[2];
        result.row3_sum       = sum_out[3];
        result.saturate_bits  = sat_out;
    end

endmodule

FILE: hdl/tick_housekeeping_counters.sv
// ============================================================================
// tick_housekeeping_counters: tick-driven housekeeping counters
// Input register, single-pass counter update, result register.
// ============================================================================
// Path: the input register takes a transaction at the accepting edge, and the
// result register takes its result when the core advances (output not stalled).
// Throughput: one transaction per cycle, set by the input and result registers
// advancing together whenever the result register is empty or being taken.
// Reset: counters return to their reset values, registers to 21600 and 60,
// and both pipeline stages empty.
module tick_housekeeping_counters #(
    parameter int NUM_ROWS = thc_pkg::ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  thc_pkg::thc_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output thc_pkg::thc_out_t               out_data,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [thc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              in_valid_reg;
    thc_pkg::thc_in_t  in_data_reg;
    logic              out_valid_reg;
    thc_pkg::thc_out_t out_data_reg;
    thc_pkg::thc_out_t result;
    logic [14:0]       reboot_limit_reg;
    logic [5:0]        period_length_reg;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reboot_limit_reg  <= thc_pkg::REBOOT_LIMIT_RESET;
            period_length_reg <= thc_pkg::PERIOD_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                thc_pkg::CFG_REBOOT_LIMIT:  reboot_limit_reg  <= cfg_data[14:0];
                thc_pkg::CFG_PERIOD_LENGTH: period_length_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    thc_core #(
        .NUM_ROWS(NUM_ROWS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (in_data_reg),
        .reboot_limit (reboot_limit_reg),
        .period_length(period_length_reg),
        .result       (result)
    );

    a_reboot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reboot_request |->
            out_data.cooldown_count == 16'hFFFF && !out_data.alert_pending &&
            !out_data.period_wrap && out_data.saturate_bits == 4'd0)
        else $error("reboot result does not show reset state");

    a_wrap_alerts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.period_wrap |-> out_data.alert_pending)
        else $error("period wrap without alert");

    a_sum_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(!out_data.row0_sum[15] && out_data.row0_sum[14]) &&
            !(!out_data.row1_sum[15] && out_data.row1_sum[14]))
        else $error("row sum at or above limit");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("pending result dropped or changed");

endmodule
